/* hdl/oal_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the ordered array list.
// No dependencies; every other file of the block imports it.
package oal_pkg;

    localparam int CAPACITY  = 128;
    localparam int WORD_BITS = 32;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W  = 8;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int FND_W  = IDX_W + 1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_RANGE = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_FIND = 1'b1
    } t_state;

    // broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic del;
        logic cmp;
    } t_cell_ctrl;

endpackage

/* hdl/oal_cell.sv */
`timescale 1ns / 1ps
// One cell of the list row: holds one entry and its last compare result.
// Depends on oal_pkg.
module oal_cell import oal_pkg::*; (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctrl       i_ctrl,
    input  logic [CMP_W-1:0] i_p0,
    input  logic [CNT_W-1:0] i_count,
    input  t_word            i_key,
    input  t_word            i_left,
    input  t_word            i_right,
    output t_word            o_word,
    output logic             o_match,
    output t_word            o_pick
);

    t_word            r_word;
    t_word            n_word;
    logic             r_match;
    logic             n_match;
    logic [CMP_W-1:0] w_idx;
    logic [CMP_W-1:0] w_cnt;

    assign w_idx = CMP_W'(i_index);
    assign w_cnt = CMP_W'(i_count);

    always_comb begin
        n_word  = r_word;
        n_match = r_match;
        if (i_ctrl.ins) begin
            if (w_idx == i_p0) begin
                n_word = i_key;
            end else if (w_idx > i_p0) begin
                n_word = i_left;
            end
        end
        if (i_ctrl.del && (w_idx >= i_p0)) begin
            n_word = i_right;
        end
        if (i_ctrl.cmp) begin
            n_match = (w_idx < w_cnt) && (r_word == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_match <= n_match;
    end

    assign o_word  = r_word;
    assign o_match = r_match;
    assign o_pick  = (w_idx == i_p0) ? r_word : '0;

endmodule

/* hdl/oal_first.sv */
`timescale 1ns / 1ps
// Finds the lowest set match flag of the cell row, as a 1-based position.
// Depends on oal_pkg.
module oal_first import oal_pkg::*; (
    input  logic [CAPACITY-1:0] i_match,
    output logic [FND_W-1:0]    o_pos
);

    always_comb begin
        o_pos = '0;
        // scan downwards so that the lowest match wins
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (i_match[k]) begin
                o_pos = FND_W'(k + 1);
            end
        end
    end

endmodule

/* hdl/ordered_array_list.sv */
`timescale 1ns / 1ps
// Ordered array list: a row of CAPACITY cells holding signed words plus a count.
// Slave channel takes requests: tuser = req_type (0 insert, 1 delete,
// 2 find, 3 no-op); tdata = position (bits 7:0), item_value (bits 39:8).
// Master channel returns one result per request: tuser = status
// (0 done, 1 position out of range, 2 list full); tdata = removed_value
// (31:0), found_position (39:32), entry_count (47:40).
// Insert and delete shift each cell at or past the position towards or from its
// neighbour in the cycle the request is taken; the result is shown the next cycle.
// Find compares every cell in the accept cycle and registers the match flags;
// the S_FIND state then picks the first match once the result register is free.
// One request is in work at a time; a new request is taken while a result
// waits, as long as the result register is free or being drained.
// If the receiver stalls, the result holds and tready drops once a further
// result would have nowhere to go.
// Reset (synchronous, active low) empties the list; no clearing pass.
// Depends on oal_pkg, oal_cell, oal_first.
module ordered_array_list import oal_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // position[7:0], item_value[39:8]
    input  logic [1:0]  i_s_axis_tuser,  // req_type[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // removed_value, found_position, entry_count
    output logic [1:0]  o_m_axis_tuser   // status[1:0]
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [31:0]         r_removed, n_removed;
    logic [7:0]          r_found, n_found;
    logic [7:0]          r_count_out, n_count_out;

    t_op                 w_op;
    logic [POS_W-1:0]    w_pos;
    t_word               w_key;
    logic [CMP_W-1:0]    w_pos_x;
    logic [CMP_W-1:0]    w_cnt_x;
    logic [CMP_W-1:0]    w_p0;
    logic                w_accept;
    logic                w_slot_free;
    t_cell_ctrl          w_ctrl;
    logic                w_full;
    logic                w_ins_bad;
    logic                w_del_bad;

    t_word               w_word [CAPACITY];
    t_word               w_pick [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    t_word               w_removed;
    logic [FND_W-1:0]    w_first;

    assign w_op    = t_op'(i_s_axis_tuser);
    assign w_pos   = i_s_axis_tdata[7:0];
    assign w_key   = WORD_BITS'(i_s_axis_tdata[39:8]);
    assign w_pos_x = CMP_W'(w_pos);
    assign w_cnt_x = CMP_W'(r_count);
    assign w_p0    = w_pos_x - CMP_W'(1);

    assign w_slot_free     = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_slot_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_full    = r_count >= CNT_W'(CAPACITY);
    assign w_ins_bad = (w_pos == '0) || (w_pos_x > (w_cnt_x + CMP_W'(1)));
    assign w_del_bad = (w_pos == '0) || (w_pos_x > w_cnt_x);

    always_comb begin
        w_ctrl.ins = w_accept && (w_op == OP_INSERT) && !w_full && !w_ins_bad;
        w_ctrl.del = w_accept && (w_op == OP_DELETE) && !w_del_bad;
        w_ctrl.cmp = w_accept && (w_op == OP_FIND);
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word w_left;
        t_word w_right;
        if (g == 0) begin : g_head
            assign w_left = w_key;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_word[g];
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end
        oal_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctrl  (w_ctrl),
            .i_p0    (w_p0),
            .i_count (r_count),
            .i_key   (w_key),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[g]),
            .o_match (w_match[g]),
            .o_pick  (w_pick[g])
        );
    end

    always_comb begin
        w_removed = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_removed = w_removed | w_pick[k];
        end
    end

    oal_first u_first (
        .i_match (w_match),
        .o_pos   (w_first)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_status    = r_status;
        n_removed   = r_removed;
        n_found     = r_found;
        n_count_out = r_count_out;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status  = STS_DONE;
                    n_removed = '0;
                    n_found   = '0;
                    unique case (w_op)
                        OP_INSERT: begin
                            if (w_full) begin
                                n_status = STS_FULL;
                            end else if (w_ins_bad) begin
                                n_status = STS_RANGE;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                            n_out_valid = 1'b1;
                        end
                        OP_DELETE: begin
                            if (w_del_bad) begin
                                n_status = STS_RANGE;
                            end else begin
                                n_removed = 32'(signed'(w_removed));
                                n_count   = r_count - CNT_W'(1);
                            end
                            n_out_valid = 1'b1;
                        end
                        OP_FIND: begin
                            n_state = S_FIND;
                        end
                        OP_NONE: begin
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                    n_count_out = 8'(n_count);
                end
            end
            S_FIND: begin
                // hold until the result register can take the find outcome
                if (w_slot_free) begin
                    n_found     = 8'(w_first);
                    n_count_out = 8'(r_count);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_removed   <= n_removed;
        r_found     <= n_found;
        r_count_out <= n_count_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_count_out, r_found, r_removed};
    assign o_m_axis_tuser  = r_status;

endmodule

/* verif/ordered_array_list_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for ordered_array_list: drives list requests over the slave stream,
// tracks the list in a scoreboard class and checks every result field by field.
// Depends on oal_pkg and the ordered_array_list RTL.
module ordered_array_list_tb;
    import oal_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    class list_scoreboard;
        typedef struct {
            t_status     status;
            logic [31:0] removed;
            logic [7:0]  found;
            logic [7:0]  count;
        } t_reply;

        t_word       list_words [CAPACITY];
        int unsigned list_len;
        t_reply      awaited_replies [$];
        int unsigned errors;
        int unsigned n_ins, n_del, n_find, n_none, n_full, n_range, n_hit, n_checked;
        bit          reached_full;

        function new();
            list_len = 0;
            errors   = 0;
        endfunction

        function int unsigned waiting();
            return awaited_replies.size();
        endfunction

        // Update the list for an accepted request and queue its expected reply.
        function void apply_request(t_op op, logic [7:0] pos, t_word value);
            t_reply r;
            r.status  = STS_DONE;
            r.removed = '0;
            r.found   = '0;
            case (op)
                OP_INSERT: begin
                    n_ins++;
                    if (list_len >= CAPACITY) begin
                        r.status = STS_FULL;
                    end else if (pos < 1 || pos > list_len + 1) begin
                        r.status = STS_RANGE;
                    end else begin
                        for (int j = list_len; j >= pos; j--)
                            list_words[j] = list_words[j-1];
                        list_words[pos-1] = value;
                        list_len++;
                    end
                end
                OP_DELETE: begin
                    n_del++;
                    if (pos < 1 || pos > list_len) begin
                        r.status = STS_RANGE;
                    end else begin
                        r.removed = list_words[pos-1];
                        for (int j = pos; j < list_len; j++)
                            list_words[j-1] = list_words[j];
                        list_len--;
                    end
                end
                OP_FIND: begin
                    n_find++;
                    for (int j = 0; j < list_len; j++) begin
                        if (list_words[j] == value) begin
                            r.found = 8'(j + 1);
                            break;
                        end
                    end
                    if (r.found != 0)
                        n_hit++;
                end
                default: n_none++;
            endcase
            if (r.status == STS_FULL)
                n_full++;
            if (r.status == STS_RANGE)
                n_range++;
            if (list_len == CAPACITY)
                reached_full = 1'b1;
            r.count = 8'(list_len);
            awaited_replies.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [1:0] st, logic [31:0] removed, logic [7:0] found,
                          logic [7:0] cnt);
            t_reply r;
            n_checked++;
            if (awaited_replies.size() == 0) begin
                report($sformatf("unexpected result status=%0d count=%0d", st, cnt));
                return;
            end
            r = awaited_replies.pop_front();
            if (st !== r.status)
                report($sformatf("status %0d, want %0d", st, r.status));
            if (removed !== r.removed)
                report($sformatf("removed_value %h, want %h", removed, r.removed));
            if (found !== r.found)
                report($sformatf("found_position %0d, want %0d", found, r.found));
            if (cnt !== r.count)
                report($sformatf("entry_count %0d, want %0d", cnt, r.count));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;   // position[7:0], item_value[39:8]
    logic [1:0]  i_s_axis_tuser;   // req_type[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;   // removed_value[31:0], found_position[39:32],
                                   // entry_count[47:40]
    logic [1:0]  o_m_axis_tuser;   // status[1:0]

    list_scoreboard sb;
    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    bit hold_armed   = 1'b0;
    bit hold_served  = 1'b0;
    int unsigned stall_cycles = 0;

    t_word word_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0005, 32'hA5A5_5A5A};

    ordered_array_list dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one request, idling at random beforehand; return once it is taken.
    task automatic send_request(t_op op, logic [7:0] pos, t_word value);
        while (src_idle_en && $urandom_range(99) < 17) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= {$urandom, 8'($urandom)};
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {value, pos};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.apply_request(op, pos, value);
    endtask

    function automatic t_word pick_word();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 3)
            return word_pool[$urandom_range(7)];
        if (r < 6 && sb.list_len > 0)
            return sb.list_words[$urandom_range(sb.list_len - 1)];
        return t_word'($urandom);
    endfunction

    // Mostly a legal position in 1..top; now and then zero, just past top, or anything.
    function automatic logic [7:0] pick_pos(int unsigned top);
        int unsigned r;
        r = $urandom_range(19);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'($urandom_range(255));
        if (r == 2)
            return 8'(top + 1);
        if (top == 0)
            return 8'd1;
        return 8'($urandom_range(top, 1));
    endfunction

    task automatic random_request(int unsigned ins_w, int unsigned del_w, int unsigned find_w);
        int unsigned r;
        r = $urandom_range(99);
        if (r < ins_w)
            send_request(OP_INSERT, pick_pos(sb.list_len + 1), pick_word());
        else if (r < ins_w + del_w)
            send_request(OP_DELETE, pick_pos(sb.list_len), pick_word());
        else if (r < ins_w + del_w + find_w)
            send_request(OP_FIND, 8'($urandom_range(255)), pick_word());
        else
            send_request(OP_NONE, 8'($urandom_range(255)), t_word'($urandom));
    endtask

    // Result side: check each accepted result and drive tready, with one long hold-off.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (o_m_axis_tvalid && i_m_axis_tready)
                    sb.check_result(o_m_axis_tuser, o_m_axis_tdata[31:0],
                                    o_m_axis_tdata[39:32], o_m_axis_tdata[47:40]);
                if (hold_armed && !hold_served) begin
                    hold_left   = HOLD_CYCLES;
                    hold_served = 1'b1;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    i_m_axis_tready <= 1'b0;
                end else begin
                    i_m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 17);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((i_s_axis_tvalid && o_s_axis_tready) ||
                     (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        sb = new();
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_NONE;
        i_m_axis_tready <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: find, bad deletes and bad inserts.
        send_request(OP_FIND,   8'd0,   32'h0000_0000);
        send_request(OP_DELETE, 8'd1,   32'h0000_0000);
        send_request(OP_DELETE, 8'd0,   32'h0000_0000);
        send_request(OP_INSERT, 8'd0,   32'h0000_0001);
        send_request(OP_INSERT, 8'd2,   32'h0000_0001);
        // Build -1, 0, min, max, 0 through head, middle and tail inserts.
        send_request(OP_INSERT, 8'd1,   32'h8000_0000);
        send_request(OP_INSERT, 8'd2,   32'h7FFF_FFFF);
        send_request(OP_INSERT, 8'd1,   32'hFFFF_FFFF);
        send_request(OP_INSERT, 8'd2,   32'h0000_0000);
        send_request(OP_INSERT, 8'd5,   32'h0000_0000);
        send_request(OP_INSERT, 8'd255, 32'h0000_0007);
        // Duplicate: the first match wins.
        send_request(OP_FIND,   8'd0,   32'h0000_0000);
        send_request(OP_FIND,   8'd0,   32'h7FFF_FFFF);
        send_request(OP_FIND,   8'd0,   32'h0000_3039);
        send_request(OP_NONE,   8'd255, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 8'd6,   32'h0000_0000);
        send_request(OP_DELETE, 8'd255, 32'h0000_0000);
        send_request(OP_DELETE, 8'd5,   32'h0000_0000);
        send_request(OP_DELETE, 8'd1,   32'h0000_0000);
        send_request(OP_DELETE, 8'd2,   32'h0000_0000);
        send_request(OP_FIND,   8'd0,   32'h8000_0000);
        // Find ignores the position field.
        send_request(OP_FIND,   8'd255, 32'h7FFF_FFFF);
        send_request(OP_DELETE, 8'd1,   32'h0000_0000);
        send_request(OP_DELETE, 8'd1,   32'h0000_0000);
        send_request(OP_FIND,   8'd0,   32'h7FFF_FFFF);

        repeat (200) random_request(45, 30, 20);

        // Fill to capacity with no idling on either side, then knock on a full list.
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        while (sb.list_len < CAPACITY)
            random_request(85, 5, 10);
        repeat (8) random_request(70, 0, 30);

        // Hold the result side off while requests keep coming.
        hold_armed = 1'b1;
        repeat (40) random_request(40, 30, 25);

        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        while (sb.list_len > 0)
            random_request(5, 85, 10);
        repeat (250) random_request(45, 30, 20);

        i_s_axis_tvalid <= 1'b0;
        while (sb.waiting() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d inserts, %0d deletes, %0d finds (%0d hits), %0d no-ops",
                 sb.n_ins, sb.n_del, sb.n_find, sb.n_hit, sb.n_none);
        $display("refused %0d full, %0d range; list full: %0d; %0d results, %0d errors",
                 sb.n_full, sb.n_range, sb.reached_full, sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
